// ===== hdl/mhf_pkg.sv =====
// Package: shared constants, command codes and the address hash function.
package mhf_pkg;

    localparam int unsigned MAC_W      = 48;
    localparam int unsigned MAC_BYTES  = 6;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned TABLE_W    = 64;

    localparam logic [31:0] HASH_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] HASH_PRESET = 32'hFFFF_FFFF;

    localparam logic [TABLE_W-1:0] TABLE_RESET = {1'b1, {(TABLE_W-1){1'b0}}};

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_ADD   = 1'b1;

    typedef logic [MAC_W-1:0]   t_mac;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [TABLE_W-1:0] t_table;

    function automatic t_idx mac_hash(input t_mac mac);
        logic [31:0] crc;
        crc = HASH_PRESET;
        for (int b = 0; b < MAC_BYTES; b++) begin
            crc = crc ^ {24'h0, mac[8*b +: 8]};
            for (int j = 0; j < 8; j++) begin
                crc = crc[0] ? ((crc >> 1) ^ HASH_POLY) : (crc >> 1);
            end
        end
        return crc[IDX_W-1:0];
    endfunction

endpackage

// ===== hdl/mhf_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
interface mhf_req_if;
    import mhf_pkg::*;
    logic valid;
    logic ready;
    logic command;
    t_mac mac_addr;
    logic entry_valid;

    modport source (output valid, output command, output mac_addr, output entry_valid,
                    input ready);
    modport sink   (input valid, input command, input mac_addr, input entry_valid,
                    output ready);
endinterface

interface mhf_rsp_if;
    import mhf_pkg::*;
    logic   valid;
    logic   ready;
    t_idx   hash_index;
    t_table hash_table;

    modport source (output valid, output hash_index, output hash_table, input ready);
    modport sink   (input valid, input hash_index, input hash_table, output ready);
endinterface

// ===== hdl/mhf_update.sv =====
// Table update: hashes the address and forms the next table and index.
module mhf_update (
    input  logic            i_command,
    input  mhf_pkg::t_mac   i_mac_addr,
    input  logic            i_entry_valid,
    input  mhf_pkg::t_table i_table,
    output mhf_pkg::t_idx   o_hash_index,
    output mhf_pkg::t_table o_table
);
    import mhf_pkg::*;

    t_idx idx;

    assign idx = mac_hash(i_mac_addr);

    always_comb begin
        unique case (i_command)
            CMD_CLEAR: begin
                o_hash_index = '0;
                o_table      = TABLE_RESET;
            end
            CMD_ADD: begin
                o_hash_index = idx;
                o_table      = i_entry_valid ? (i_table | (t_table'(1) << idx)) : i_table;
            end
            default: begin
                o_hash_index = '0;
                o_table      = i_table;
            end
        endcase
    end

endmodule

// ===== hdl/multicast_hash_filter_builder_unit.sv =====
// Top level: multicast hash filter builder with input and result registers.
// Request accept to response valid passes the input then the result register.
// Throughput: one request per cycle unless o_rsp stalls; the hash is a fixed XOR
// network between the input and result registers, and the table updates in step.
// Reset: synchronous, active low; clears both stages and sets the table to
// the broadcast bit only.
module multicast_hash_filter_builder_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mhf_req_if.sink   i_req,
    mhf_rsp_if.source o_rsp
);
    import mhf_pkg::*;

    logic   r_s1_valid;
    logic   r_s1_cmd;
    t_mac   r_s1_mac;
    logic   r_s1_entry_valid;

    logic   r_out_valid;
    t_idx   r_out_idx;
    t_table r_out_table;
    t_table r_filter_table;

    t_idx   n_idx;
    t_table n_table;
    logic   out_adv;
    logic   s1_adv;
    logic   in_take;

    assign out_adv = !r_out_valid || o_rsp.ready;
    assign s1_adv  = r_s1_valid && out_adv;
    assign in_take = i_req.valid && i_req.ready;

    assign i_req.ready = !r_s1_valid || out_adv;

    mhf_update u_update (
        .i_command     (r_s1_cmd),
        .i_mac_addr    (r_s1_mac),
        .i_entry_valid (r_s1_entry_valid),
        .i_table       (r_filter_table),
        .o_hash_index  (n_idx),
        .o_table       (n_table)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd         <= i_req.command;
            r_s1_mac         <= i_req.mac_addr;
            r_s1_entry_valid <= i_req.entry_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_filter_table <= TABLE_RESET;
        end else begin
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_filter_table <= n_table;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_idx   <= n_idx;
            r_out_table <= n_table;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hash_index = r_out_idx;
    assign o_rsp.hash_table = r_out_table;

    a_reset_table : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_filter_table == TABLE_RESET)
        else $error("table not at broadcast-only value after reset");

    a_bcast_set : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filter_table[TABLE_W-1])
        else $error("broadcast bit lost");

    a_rsp_matches_table : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_table == r_filter_table)
        else $error("pending response table differs from filter table");

    a_add_keeps_bits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_cmd == CMD_ADD) |=>
            (r_filter_table & $past(r_filter_table)) == $past(r_filter_table))
        else $error("add request dropped table bits");

    a_clear_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_cmd == CMD_CLEAR) |=> r_out_idx == '0)
        else $error("clear request gave nonzero index");

endmodule

// ===== bench/mhf_scoreboard.sv =====
// Scoreboard: watches both channels, models the filter table and checks every response.
module mhf_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    mhf_req_if   i_req,
    mhf_rsp_if   i_rsp,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mhf_pkg::*;

    typedef struct {
        t_idx   bucket;
        t_table filter;
    } filter_result_t;

    filter_result_t expected_filters[$];
    t_table         shadow_table;
    int             mismatch_count;

    // Reflected CRC-32 over the address, one bit at a time, low bit of byte 0 first.
    function automatic t_idx crc_bucket(input t_mac mac);
        logic [31:0] crc;
        logic        fb;
        crc = HASH_PRESET;
        for (int i = 0; i < MAC_W; i++) begin
            fb  = crc[0] ^ mac[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ HASH_POLY;
            end
        end
        return crc[IDX_W-1:0];
    endfunction

    initial begin
        mismatch_count = 0;
        shadow_table   = TABLE_RESET;
        o_errors       = 0;
        o_pending      = 0;
    end

    always @(posedge i_clk) begin
        filter_result_t exp_r;
        filter_result_t next_r;
        if (!i_rst_n) begin
            shadow_table = TABLE_RESET;
            expected_filters.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_filters.size() == 0) begin
                    $error("response with nothing outstanding: hash_index %0h hash_table %0h",
                           i_rsp.hash_index, i_rsp.hash_table);
                    mismatch_count++;
                end else begin
                    exp_r = expected_filters.pop_front();
                    if (i_rsp.hash_index !== exp_r.bucket) begin
                        $error("hash_index: expected %0h, actual %0h",
                               exp_r.bucket, i_rsp.hash_index);
                        mismatch_count++;
                    end
                    if (i_rsp.hash_table !== exp_r.filter) begin
                        $error("hash_table: expected %016h, actual %016h",
                               exp_r.filter, i_rsp.hash_table);
                        mismatch_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                next_r.bucket = '0;
                if (i_req.command == CMD_CLEAR) begin
                    shadow_table = TABLE_RESET;
                end else begin
                    next_r.bucket = crc_bucket(i_req.mac_addr);
                    if (i_req.entry_valid) begin
                        shadow_table[next_r.bucket] = 1'b1;
                    end
                end
                next_r.filter = shadow_table;
                expected_filters.push_back(next_r);
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= expected_filters.size();
    end

endmodule

// ===== bench/multicast_hash_filter_builder_unit_tb.sv =====
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
module multicast_hash_filter_builder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhf_pkg::*;

    localparam int NUM_REQUESTS = 550;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   quiet;
    int   sent;
    int   n_clear;
    int   n_add;
    int   n_skip;
    t_mac seen_macs[$];

    mhf_req_if req ();
    mhf_rsp_if rsp ();

    multicast_hash_filter_builder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    mhf_scoreboard u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_rsp     (rsp),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic t_mac rand_mac();
        t_mac m;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 12 && seen_macs.size() > 0) begin
            m = seen_macs[$urandom_range(0, seen_macs.size() - 1)];
        end else if (r < 15) begin
            m = '0;
        end else if (r < 18) begin
            m = '1;
        end else begin
            m[47:32] = 16'($urandom);
            m[31:0]  = $urandom;
        end
        return m;
    endfunction

    task automatic send_request(input logic cmd, input t_mac mac, input logic ev);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.command     <= cmd;
        req.mac_addr    <= mac;
        req.entry_valid <= ev;
        do @(posedge i_clk); while (!req.ready);
        sent++;
        if (cmd == CMD_CLEAR) begin
            n_clear++;
        end else if (ev) begin
            n_add++;
            seen_macs.push_back(mac);
        end else begin
            n_skip++;
        end
    endtask

    // Response back-pressure: random stalls, none while quiet.
    initial begin
        int stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp.ready <= 1'b0;
            end else if (stall_left > 0) begin
                rsp.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = idle_len();
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int   run_len;
        t_mac m;
        sent    = 0;
        n_clear = 0;
        n_add   = 0;
        n_skip  = 0;
        quiet   = 1'b1;
        i_rst_n         <= 1'b0;
        req.valid       <= 1'b0;
        req.command     <= CMD_CLEAR;
        req.mac_addr    <= '0;
        req.entry_valid <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_ADD,   48'h0,              1'b1);
        send_request(CMD_ADD,   48'hFFFF_FFFF_FFFF, 1'b1);
        send_request(CMD_ADD,   48'h0,              1'b1);
        send_request(CMD_ADD,   48'h0100_005E_0001, 1'b0);
        send_request(CMD_CLEAR, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_request(CMD_ADD,   48'h0100_005E_0001, 1'b1);
        send_request(CMD_ADD,   48'hAAAA_AAAA_AAAA, 1'b1);
        quiet = 1'b0;
        send_request(CMD_ADD,   48'h5555_5555_5555, 1'b1);
        send_request(CMD_ADD,   48'h0000_0000_0001, 1'b1);
        send_request(CMD_ADD,   48'h8000_0000_0000, 1'b1);
        send_request(CMD_ADD,   48'hFFFF_FFFF_FFFF, 1'b0);
        send_request(CMD_CLEAR, 48'h1234_5678_9ABC, 1'b0);
        send_request(CMD_ADD,   48'h3333_0000_0001, 1'b1);
        send_request(CMD_CLEAR, 48'h0,              1'b0);

        // Runs of adds between clears; long runs fill the table up.
        while (sent < NUM_REQUESTS) begin
            quiet = ($urandom_range(0, 3) == 0);
            m[47:32] = 16'($urandom);
            m[31:0]  = $urandom;
            send_request(CMD_CLEAR, m, 1'($urandom));
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 300)
                                                  : $urandom_range(1, 40);
            for (int k = 0; k < run_len && sent < NUM_REQUESTS; k++) begin
                send_request(CMD_ADD, rand_mac(), $urandom_range(0, 9) != 0);
            end
        end
        quiet = 1'b0;
        req.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests: %0d clears, %0d valid adds, %0d skipped adds.",
                 sent, n_clear, n_add, n_skip);
        $display("Responses checked under random source gaps and sink stalls.");
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
